### hw/rtl/tspr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspr_pkg
// Shared constants, codes and types for the tile and sprite pixel renderer.
// ----------------------------------------------------------------------------
package tspr_pkg;

    localparam int SCREEN_WIDTH_DEF       = 160;
    localparam int SCREEN_HEIGHT_DEF      = 144;
    localparam int SPRITE_TABLE_BYTES_DEF = 160;
    localparam int VIDEO_MEMORY_BYTES     = 8192;

    localparam int VADDR_W = 13;

    localparam logic [1:0] KIND_VRAM   = 2'd0;
    localparam logic [1:0] KIND_SPRITE = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    localparam logic [1:0] REG_LCDC = 2'd0;
    localparam logic [1:0] REG_SCX  = 2'd1;
    localparam logic [1:0] REG_SCY  = 2'd2;
    localparam logic [1:0] REG_BGP  = 2'd3;

    localparam logic [12:0] MAP_LOW_BASE     = 13'h1800;
    localparam logic [12:0] MAP_HIGH_BASE    = 13'h1C00;
    localparam logic [12:0] DATA_SIGNED_BASE = 13'h0800;
    localparam logic [7:0]  SPRITE_Y_BIAS    = 8'd16;
    localparam logic [7:0]  SPRITE_X_BIAS    = 8'd8;
    localparam logic [7:0]  SIGNED_ID_FLIP   = 8'd128;
    localparam logic [1:0]  SHADE_MASK       = 2'b11;

    // sprite hit that travels along the cell chain
    typedef struct packed {
        logic       hit;
        logic [7:0] tile;
        logic [2:0] sx;
        logic [2:0] sy;
    } t_hit;

    // pick the shade of a color number from a palette byte
    function automatic logic [1:0] pal_map(input logic [7:0] pal, input logic [1:0] num);
        logic [1:0] s;
        begin
            case (num)
                2'd0:    s = pal[1:0];
                2'd1:    s = pal[3:2];
                2'd2:    s = pal[5:4];
                default: s = pal[7:6];
            endcase
            return s & SHADE_MASK;
        end
    endfunction

endpackage

### hw/rtl/tspr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspr_cell
// One sprite slot: holds a four byte entry, tests it against the pixel and
// passes the latest covering hit on to its neighbor.
// ----------------------------------------------------------------------------
module tspr_cell
    import tspr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_we,
    input  logic [1:0] i_byte,
    input  logic [7:0] i_data,
    input  logic [7:0] i_px,
    input  logic [7:0] i_ln,
    input  t_hit       i_hit,
    output t_hit       o_hit
);
    logic [7:0] r_y, r_x, r_tile, r_flags;
    logic [7:0] top, left, dy, dx;
    logic       covering;
    t_hit       r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y <= '0; r_x <= '0; r_tile <= '0; r_flags <= '0;
        end else if (i_we) begin
            case (i_byte)
                2'd0:    r_y     <= i_data;
                2'd1:    r_x     <= i_data;
                2'd2:    r_tile  <= i_data;
                default: r_flags <= i_data;
            endcase
        end
    end

    always_comb begin
        top   = r_y - SPRITE_Y_BIAS;
        left  = r_x - SPRITE_X_BIAS;
        dy    = i_ln - top;
        dx    = i_px - left;
        // column beyond the screen is dropped, no wrap
        covering = (r_y >= SPRITE_Y_BIAS)
                 && ({1'b0, r_y} < 9'(SCREEN_HEIGHT) + 9'(SPRITE_Y_BIAS))
                 && ({1'b0, left} < 9'(SCREEN_WIDTH))
                 && (i_ln >= top) && (dy < 8'd8)
                 && (i_px >= left) && (dx < 8'd8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= '0;
        end else if (covering) begin
            r_hit.hit  <= 1'b1;
            r_hit.tile <= r_tile;
            r_hit.sy   <= r_flags[6] ? ~dy[2:0] : dy[2:0];
            r_hit.sx   <= r_flags[5] ? ~dx[2:0] : dx[2:0];
        end else begin
            r_hit <= i_hit;
        end
    end

    assign o_hit = r_hit;
endmodule

### hw/rtl/tile_sprite_pixel_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_sprite_pixel_renderer
// Background tile renderer with a chain of sprite cells and a screen store.
// ----------------------------------------------------------------------------
// write requests never raise busy; a render request walks the pixel through the
// sprite cell chain, one cell per cycle, and reads the single video memory port
// and the screen store serially, one read after another.
// one request at a time; busy is high from accept until the shade strobe.
// after reset the screen store is swept to zero, one pixel a cycle, with busy
// high; the receiver cannot stall.
module tile_sprite_pixel_renderer
    import tspr_pkg::*;
#(
    parameter int SCREEN_WIDTH       = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT      = SCREEN_HEIGHT_DEF,
    parameter int SPRITE_TABLE_BYTES = SPRITE_TABLE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic [VADDR_W-1:0] i_address,
    input  logic [7:0]         i_write_data,
    input  logic [7:0]         i_pixel_x,
    input  logic [7:0]         i_line,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output logic               o_shade_valid,
    output logic [1:0]         o_shade
);
    localparam int NCELL  = SPRITE_TABLE_BYTES / 4;
    localparam int CW     = $clog2(NCELL + 1);
    localparam int NPIX   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int PW     = $clog2(NPIX);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_MAP   = 4'd2;
    localparam logic [3:0] ST_MAPW  = 4'd3;
    localparam logic [3:0] ST_LO    = 4'd4;
    localparam logic [3:0] ST_HI    = 4'd5;
    localparam logic [3:0] ST_CHAIN = 4'd6;
    localparam logic [3:0] ST_SLO   = 4'd7;
    localparam logic [3:0] ST_SHI   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0] r_state, n_state;
    logic [7:0] r_lcdc, r_scx, r_scy, r_bgp;
    logic [7:0] r_px, r_ln;
    logic [PW-1:0] r_cell, r_clr;
    logic [CW-1:0] r_cnt;
    logic [1:0] r_shade;
    logic [7:0] r_id, r_lo;
    logic [2:0] r_bxl, r_byl;
    logic       r_valid;
    logic [7:0] vram [VIDEO_MEMORY_BYTES];
    logic [1:0] scr  [NPIX];
    logic [VADDR_W-1:0] rd_addr;
    logic [7:0] r_rd;
    logic [1:0] r_scr_rd;
    logic       accept;
    t_hit       chain [NCELL+1];
    t_hit       r_sh;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc <= '0; r_scx <= '0; r_scy <= '0; r_bgp <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LCDC: r_lcdc <= i_cfg_data;
                REG_SCX:  r_scx  <= i_cfg_data;
                REG_SCY:  r_scy  <= i_cfg_data;
                default:  r_bgp  <= i_cfg_data;
            endcase
        end
    end

    // background coordinates
    logic [7:0] bx, by, sprite_id;
    logic [2:0] bit_sel;
    logic [VADDR_W-1:0] map_base, tile_base;
    always_comb begin
        bx        = r_px + r_scx;
        by        = r_ln + r_scy;
        map_base  = r_lcdc[3] ? MAP_HIGH_BASE : MAP_LOW_BASE;
        tile_base = r_lcdc[4] ? {1'b0, r_id, 4'd0}
                              : DATA_SIGNED_BASE + {1'b0, r_id ^ SIGNED_ID_FLIP, 4'd0};
        sprite_id = r_sh.tile;
        rd_addr   = '0;
        unique case (r_state)
            ST_MAP:  rd_addr = map_base + {3'd0, by[7:3], bx[7:3]};
            ST_LO:   rd_addr = tile_base + {9'd0, r_byl, 1'b0};
            ST_HI:   rd_addr = tile_base + {9'd0, r_byl, 1'b1};
            ST_SLO:  rd_addr = {1'b0, sprite_id, r_sh.sy, 1'b0};
            ST_SHI:  rd_addr = {1'b0, sprite_id, r_sh.sy, 1'b1};
            default: rd_addr = '0;
        endcase
        // sprite bit planes land in done, background planes in the first chain cycle
        bit_sel = 3'd7 - ((r_state == ST_DONE) ? r_sh.sx : r_bxl);
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_kind == KIND_VRAM) vram[i_address] <= i_write_data;
        r_rd <= vram[rd_addr];
    end

    logic scr_we;
    logic [PW-1:0] scr_wa;
    logic [1:0] scr_wd;
    always_comb begin
        scr_we = (r_state == ST_CLEAR) || (r_state == ST_DONE && r_valid && r_lcdc[7]);
        scr_wa = (r_state == ST_CLEAR) ? r_clr : r_cell;
        scr_wd = (r_state == ST_CLEAR) ? 2'd0 : r_shade;
    end
    always_ff @(posedge i_clk) begin
        if (scr_we) scr[scr_wa] <= scr_wd;
        r_scr_rd <= scr[r_cell];
    end

    // sprite cell chain; later cells override, so feed from cell 0 upward
    assign chain[0] = '0;
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        tspr_cell #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_we   (accept && i_kind == KIND_SPRITE
                     && i_address[VADDR_W-1:2] == (VADDR_W-2)'(g)),
            .i_byte (i_address[1:0]),
            .i_data (i_write_data),
            .i_px   (r_px),
            .i_ln   (r_ln),
            .i_hit  (chain[g]),
            .o_hit  (chain[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == PW'(NPIX - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept && i_kind == KIND_RENDER) n_state = ST_MAP;
            ST_MAP:   n_state = ST_MAPW;
            ST_MAPW:  n_state = ST_LO;
            ST_LO:    n_state = ST_HI;
            ST_HI:    n_state = ST_CHAIN;
            ST_CHAIN: if (r_cnt == CW'(NCELL)) n_state = ST_SLO;
            ST_SLO:   n_state = ST_SHI;
            ST_SHI:   n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr         <= '0;
            r_cnt         <= '0;
            o_shade_valid <= 1'b0;
        end else begin
            r_state       <= n_state;
            o_shade_valid <= (r_state == ST_DONE);
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            r_cnt <= (r_state == ST_CHAIN) ? r_cnt + 1'b1 : '0;
        end
    end

    // datapath; reads are registered and land in the state after their address state
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px    <= i_pixel_x;
            r_ln    <= i_line;
            r_valid <= ({1'b0, i_pixel_x} < 9'(SCREEN_WIDTH))
                       && ({1'b0, i_line} < 9'(SCREEN_HEIGHT));
            r_cell  <= PW'(32'(i_line) * SCREEN_WIDTH + 32'(i_pixel_x));
        end
        case (r_state)
            ST_MAP: begin
                r_bxl <= bx[2:0];
                r_byl <= by[2:0];
            end
            ST_MAPW: r_id <= r_rd;
            ST_HI:   r_lo <= r_rd;
            ST_CHAIN: begin
                if (r_cnt == '0) begin
                    r_shade <= r_lcdc[0]
                        ? pal_map(r_bgp, {r_rd[bit_sel], r_lo[bit_sel]}) : r_scr_rd;
                end
                r_sh <= chain[NCELL];
            end
            ST_SHI: r_lo <= r_rd;
            ST_DONE: begin
                if (r_lcdc[1] && r_sh.hit)
                    r_shade <= pal_map(r_bgp, {r_rd[bit_sel], r_lo[bit_sel]});
            end
            default: ;
        endcase
    end

    always_comb begin
        if (!r_valid)
            o_shade = 2'd0;
        else if (!r_lcdc[7])
            o_shade = r_scr_rd;
        else
            o_shade = r_shade;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_shade_valid |-> $past(r_state) == ST_DONE)
        else $error("strobe without finished render");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && start && i_kind == KIND_RENDER) |=> busy)
        else $error("render accepted but not busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHAIN) |-> r_cnt <= CW'(NCELL))
        else $error("chain counter overrun");
endmodule

### tb/sv/tspr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspr_checker
// Watches the request, register and shade ports of the pixel renderer. It keeps
// its own copy of video memory, sprite table, screen store and registers. It
// predicts the shade of every accepted render request and compares it with
// each strobed shade, in order.
// ----------------------------------------------------------------------------
module tspr_checker
    import tspr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_kind,
    input  logic [VADDR_W-1:0] i_address,
    input  logic [7:0]         i_write_data,
    input  logic [7:0]         i_pixel_x,
    input  logic [7:0]         i_line,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               o_shade_valid,
    input  logic [1:0]         o_shade,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int NPIX = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF;

    logic [7:0] vram_copy [VIDEO_MEMORY_BYTES];
    logic [7:0] oam_copy  [SPRITE_TABLE_BYTES_DEF];
    logic [1:0] screen_copy [NPIX];
    logic [7:0] lcdc, scx, scy, bgp;
    logic [1:0] shade_q [$];
    int         fails;

    assign o_fail_count = fails;
    assign o_pending    = shade_q.size();

    function automatic logic [1:0] tile_pixel(input int base, input int col, input int row);
        int         at;
        int         bit_n;
        logic [1:0] num;
        at    = base + (row & 7) * 2;
        bit_n = 7 - (col & 7);
        num   = {vram_copy[(at + 1) % VIDEO_MEMORY_BYTES][bit_n],
                 vram_copy[at % VIDEO_MEMORY_BYTES][bit_n]};
        return bgp[num*2 +: 2];
    endfunction

    function automatic logic [1:0] bg_pixel(input int px, input int ln);
        int bx, by, map, id, base;
        bx  = (px + scx) & 255;
        by  = (ln + scy) & 255;
        map = lcdc[3] ? int'(MAP_HIGH_BASE) : int'(MAP_LOW_BASE);
        id  = vram_copy[map + (by / 8) * 32 + bx / 8];
        if (lcdc[4]) begin
            base = 0;
        end else begin
            base = DATA_SIGNED_BASE;
            id   = id ^ int'(SIGNED_ID_FLIP);
        end
        return tile_pixel(base + id * 16, bx % 8, by % 8);
    endfunction

    function automatic logic [1:0] render_pixel(input int px, input int ln);
        logic [1:0] s;
        int         top, left, sx, sy;
        if (px >= SCREEN_WIDTH_DEF || ln >= SCREEN_HEIGHT_DEF) return 2'd0;
        s = screen_copy[ln * SCREEN_WIDTH_DEF + px];
        if (!lcdc[7]) return s;
        if (lcdc[0]) s = bg_pixel(px, ln);
        if (lcdc[1]) begin
            // last covering sprite in table order wins
            for (int k = 0; k + 4 <= SPRITE_TABLE_BYTES_DEF; k += 4) begin
                if (oam_copy[k] < 16 || oam_copy[k] >= SCREEN_HEIGHT_DEF + 16) continue;
                top  = oam_copy[k] - 16;
                left = (int'(oam_copy[k+1]) - 8) & 255;
                if (ln < top || ln >= top + 8) continue;
                if (px < left || px >= left + 8) continue;
                sy = ln - top;
                sx = px - left;
                if (oam_copy[k+3][6]) sy = 7 - sy;
                if (oam_copy[k+3][5]) sx = 7 - sx;
                s = tile_pixel(int'(oam_copy[k+2]) * 16, sx, sy);
            end
        end
        screen_copy[ln * SCREEN_WIDTH_DEF + px] = s;
        return s;
    endfunction

    always @(posedge i_clk) begin
        logic [1:0] want;
        if (!i_rst_n) begin
            lcdc <= '0;
            scx  <= '0;
            scy  <= '0;
            bgp  <= '0;
            foreach (oam_copy[k]) oam_copy[k] = '0;
            foreach (screen_copy[k]) screen_copy[k] = '0;
            shade_q.delete();
            fails <= 0;
        end else begin
            if (o_shade_valid) begin
                if (shade_q.size() == 0) begin
                    if (fails < 10) $display("shade %0d strobed with no request pending", o_shade);
                    fails <= fails + 1;
                end else begin
                    want = shade_q.pop_front();
                    if (want !== o_shade) begin
                        if (fails < 10) $display("shade mismatch: expected %0d got %0d", want, o_shade);
                        fails <= fails + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LCDC: lcdc <= i_cfg_data;
                    REG_SCX:  scx  <= i_cfg_data;
                    REG_SCY:  scy  <= i_cfg_data;
                    REG_BGP:  bgp  <= i_cfg_data;
                endcase
            end
            if (start && !busy) begin
                case (i_kind)
                    KIND_VRAM:   vram_copy[i_address] = i_write_data;
                    KIND_SPRITE: if (i_address < SPRITE_TABLE_BYTES_DEF)
                                     oam_copy[i_address[7:0]] = i_write_data;
                    KIND_RENDER: shade_q.push_back(render_pixel(i_pixel_x, i_line));
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/tb_tile_sprite_pixel_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_sprite_pixel_renderer
// Fills video memory, then runs directed and random write and render
// requests through the renderer in bursts. The register settings change
// between phases.
// ----------------------------------------------------------------------------
module tb_tile_sprite_pixel_renderer;
    import tspr_pkg::*;

    // request kind that the renderer ignores
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_kind = KIND_VRAM;
    logic [VADDR_W-1:0] i_address = '0;
    logic [7:0]         i_write_data = '0;
    logic [7:0]         i_pixel_x = '0;
    logic [7:0]         i_line = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = REG_LCDC;
    logic [7:0]         i_cfg_data = '0;
    logic               o_shade_valid;
    logic [1:0]         o_shade;
    int                 fail_count;
    int                 pending;
    int                 burst_left;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    tile_sprite_pixel_renderer u_top (.*);

    tspr_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_kind, .i_address, .i_write_data,
        .i_pixel_x, .i_line, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_shade_valid, .o_shade, .o_fail_count(fail_count), .o_pending(pending)
    );

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // waits for the edge that takes the request; start stays high unless a pause follows
    task automatic issue(input logic [1:0] kind, input int addr, input int data,
                         input int px, input int ln);
        i_kind       <= kind;
        i_address    <= VADDR_W'(addr);
        i_write_data <= 8'(data);
        i_pixel_x    <= 8'(px);
        i_line       <= 8'(ln);
        start        <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 15));
        end
    endtask

    task automatic settle();
        pause(1);
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        // a trailing write request gives no strobe
        repeat (60) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_regs(input int lcdc, input int scx, input int scy, input int bgp);
        logic [7:0] vals [4];
        vals = '{8'(lcdc), 8'(scx), 8'(scy), 8'(bgp)};
        settle();
        for (int r = 0; r < 4; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 2'(r);
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_request();
        int pick, addr, data;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            case ($urandom_range(0, 9))
                0:       addr = $urandom_range(0, 8191);
                1, 2, 3: addr = $urandom_range(0, 16'h17FF);
                default: addr = $urandom_range(16'h1800, 16'h1FFF);
            endcase
            issue(KIND_VRAM, addr, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
        end else if (pick < 45) begin
            addr = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191)
                                                : $urandom_range(0, 159);
            case (addr % 4)
                0:       data = $urandom_range(10, 165);
                1:       data = $urandom_range(0, 175);
                default: data = $urandom_range(0, 255);
            endcase
            issue(KIND_SPRITE, addr, data, $urandom_range(0, 255), $urandom_range(0, 255));
        end else if (pick < 95) begin
            if ($urandom_range(0, 9) == 0)
                issue(KIND_RENDER, $urandom_range(0, 8191), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
            else
                issue(KIND_RENDER, $urandom_range(0, 8191), $urandom_range(0, 255),
                      $urandom_range(0, 159), $urandom_range(0, 143));
        end else begin
            issue(KIND_IGNORED, $urandom_range(0, 8191), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
        end
    endtask

    initial begin
        int lcdc_set [7];
        int scx_set  [7];
        int bgp_set  [7];
        lcdc_set = '{8'h93, 8'h83, 8'hFF, 8'h80, 8'h00, 8'h9B, 8'h91};
        scx_set  = '{0, 255, 3, 128, 0, 77, 255};
        bgp_set  = '{8'hE4, 8'h1B, 8'hFF, 8'h00, 8'hE4, 8'h6C, 8'h93};
        burst_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every video memory byte written before any render reads it
        for (int a = 0; a < VIDEO_MEMORY_BYTES; a++)
            issue(KIND_VRAM, a, $urandom_range(0, 255), 0, 0);

        set_regs(8'h93, 0, 0, 8'hE4);
        // sprites: plain at the corner, flipped, and one with its column off screen
        issue(KIND_SPRITE, 0, 16, 0, 0);
        issue(KIND_SPRITE, 1, 8, 0, 0);
        issue(KIND_SPRITE, 2, 1, 0, 0);
        issue(KIND_SPRITE, 3, 0, 0, 0);
        issue(KIND_RENDER, 0, 0, 0, 0);
        issue(KIND_RENDER, 0, 0, 7, 7);
        issue(KIND_RENDER, 0, 0, 8, 0);
        issue(KIND_SPRITE, 4, 20, 0, 0);
        issue(KIND_SPRITE, 5, 12, 0, 0);
        issue(KIND_SPRITE, 6, 255, 0, 0);
        issue(KIND_SPRITE, 7, 8'h60, 0, 0);
        issue(KIND_RENDER, 0, 0, 5, 5);
        issue(KIND_SPRITE, 156, 159, 0, 0);
        issue(KIND_SPRITE, 157, 0, 0, 0);
        issue(KIND_RENDER, 0, 0, 0, 143);
        issue(KIND_RENDER, 0, 0, 159, 143);
        issue(KIND_RENDER, 0, 0, 160, 0);
        issue(KIND_RENDER, 0, 0, 0, 144);
        issue(KIND_RENDER, 0, 0, 255, 255);
        issue(KIND_IGNORED, 8191, 255, 0, 0);
        issue(KIND_SPRITE, 160, 255, 0, 0);
        issue(KIND_SPRITE, 8191, 255, 0, 0);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6)
                set_regs($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
            else
                set_regs(lcdc_set[ph], scx_set[ph], 255 - scx_set[ph], bgp_set[ph]);
            repeat (260) random_request();
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
